FILE: design/lls_pkg.sv
// lls_pkg: shared types and constants of the lifter limit-switch drive unit
// no dependencies; used by the register file, the step logic and the top level
`default_nettype none

package lls_pkg;

    localparam int SPEED_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int COUNT_W   = 32;
    localparam int MAG_W     = 15;
    localparam int MARGIN_W  = 16;
    localparam int APC_W     = 16;
    localparam int BIAS_W    = 12;
    localparam int REQ_W     = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_MANUAL   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GOTO     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HOLD_TOP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ZERO     = 2'd3;

    // gravity hold bias per encoder band
    localparam logic signed [BIAS_W-1:0]  BIAS_LOW  = 12'sd0;
    localparam logic signed [BIAS_W-1:0]  BIAS_MID  = -12'sd655;
    localparam logic signed [BIAS_W-1:0]  BIAS_HIGH = -12'sd1966;
    localparam logic signed [COUNT_W-1:0] BAND_MID  = 32'sd100;
    localparam logic signed [COUNT_W-1:0] BAND_HIGH = 32'sd200;

    // configuration register map
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_CAP       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_MARGIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_APPROACH_SPEED  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_PER_COUNT = 3'd4;

    localparam logic [MAG_W-1:0]    DEADBAND_RST        = 15'd3277;
    localparam logic [MAG_W-1:0]    SPEED_CAP_RST       = 15'd16384;
    localparam logic [MARGIN_W-1:0] ANGLE_MARGIN_RST    = 16'd512;
    localparam logic [MAG_W-1:0]    APPROACH_SPEED_RST  = 15'd9830;
    localparam logic [APC_W-1:0]    ANGLE_PER_COUNT_RST = 16'd256;

    typedef struct packed {
        logic [MAG_W-1:0]    deadband;
        logic [MAG_W-1:0]    speed_cap;
        logic [MARGIN_W-1:0] angle_margin;
        logic [MAG_W-1:0]    approach_speed;
        logic [APC_W-1:0]    angle_per_count;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [SPEED_W-1:0] lifter_speed;
        logic signed [ANGLE_W-1:0] target_angle;
        logic signed [COUNT_W-1:0] encoder_raw;
        logic                      low_switch_a;
        logic                      low_switch_b;
        logic                      high_switch_a;
        logic                      high_switch_b;
    } req_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] lifter_drive;
        logic                      target_reached;
        logic                      top_flag;
        logic signed [COUNT_W-1:0] position_count;
    } rsp_t;

    typedef struct packed {
        logic signed [BIAS_W-1:0]  hold_bias;
        logic                      top_latched;
        logic signed [COUNT_W-1:0] count_offset;
        logic signed [SPEED_W-1:0] last_drive;
    } state_t;

endpackage

`default_nettype wire

FILE: design/lls_if.sv
// lls_req_if / lls_rsp_if: valid-ready channels for requests and results
// depends on lls_pkg for field widths
`default_nettype none

interface lls_req_if;
    logic                               valid;
    logic                               ready;
    logic [lls_pkg::REQ_W-1:0]          req_type;
    logic signed [lls_pkg::SPEED_W-1:0] lifter_speed;
    logic signed [lls_pkg::ANGLE_W-1:0] target_angle;
    logic signed [lls_pkg::COUNT_W-1:0] encoder_raw;
    logic                               low_switch_a;
    logic                               low_switch_b;
    logic                               high_switch_a;
    logic                               high_switch_b;

    modport source (
        output valid, req_type, lifter_speed, target_angle, encoder_raw,
               low_switch_a, low_switch_b, high_switch_a, high_switch_b,
        input  ready
    );
    modport sink (
        input  valid, req_type, lifter_speed, target_angle, encoder_raw,
               low_switch_a, low_switch_b, high_switch_a, high_switch_b,
        output ready
    );
endinterface

interface lls_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [lls_pkg::SPEED_W-1:0] lifter_drive;
    logic                               target_reached;
    logic                               top_flag;
    logic signed [lls_pkg::COUNT_W-1:0] position_count;

    modport source (
        output valid, lifter_drive, target_reached, top_flag, position_count,
        input  ready
    );
    modport sink (
        input  valid, lifter_drive, target_reached, top_flag, position_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/lifter_limit_switch_drive_unit.sv
// lifter_limit_switch_drive_unit: top level of the lifter drive block
// depends on lls_pkg, lls_if, lls_regs and lls_step
`default_nettype none

// Lifter motor drive with limit switches, gravity hold bias and encoder zeroing.
// Each request transaction gives exactly one result transaction. A request is
// captured in an input register, the whole step (position subtract, one
// 32x17 angle multiply, compare, clamp and saturate) runs combinationally from
// there into the result register, and the lifter state is updated in the same
// edge. One transaction per clock is sustained while results are taken; a result
// passes through the input register and then the result register, and a stalled
// result holds the input stage only once both registers are full. Configuration
// registers sit on the APB port at byte addresses 0x00 deadband, 0x04 speed_cap,
// 0x08 angle_margin, 0x0c approach_speed and 0x10 angle_per_count; write them only while idle.
module lifter_limit_switch_drive_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lls_req_if.sink                          req,
    lls_rsp_if.source                        rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lls_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    lls_pkg::cfg_t    cfg;
    lls_pkg::req_t    req_in;
    lls_pkg::req_t    in_reg;
    lls_pkg::rsp_t    out_reg;
    lls_pkg::rsp_t    step_rsp;
    lls_pkg::state_t  st_reg;
    lls_pkg::state_t  st_next;
    logic             in_vld_reg;
    logic             in_vld_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             in_take;
    logic             advance;

    lls_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lls_step u_step (
        .cfg    (cfg),
        .req    (in_reg),
        .st     (st_reg),
        .st_out (st_next),
        .rsp    (step_rsp)
    );

    assign req_in.req_type      = req.req_type;
    assign req_in.lifter_speed  = req.lifter_speed;
    assign req_in.target_angle  = req.target_angle;
    assign req_in.encoder_raw   = req.encoder_raw;
    assign req_in.low_switch_a  = req.low_switch_a;
    assign req_in.low_switch_b  = req.low_switch_b;
    assign req_in.high_switch_a = req.high_switch_a;
    assign req_in.high_switch_b = req.high_switch_b;

    // the input stage moves on whenever the result register is free or drains
    assign advance      = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready    = !in_vld_reg || advance;
    assign in_take      = req.valid && req.ready;
    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            st_reg.hold_bias    <= lls_pkg::BIAS_LOW;
            st_reg.top_latched  <= 1'b1;
            st_reg.count_offset <= '0;
            st_reg.last_drive   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= req_in;
        if (advance)
            out_reg <= step_rsp;
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.lifter_drive   = out_reg.lifter_drive;
    assign rsp.target_reached = out_reg.target_reached;
    assign rsp.top_flag       = out_reg.top_flag;
    assign rsp.position_count = out_reg.position_count;

`ifndef SYNTH
    // zeroing the encoder makes the reported position zero
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.req_type == lls_pkg::REQ_ZERO)
        |=> (out_reg.position_count == '0))
        else $error("position not zero after encoder zero transaction");

    // only a go-to-angle transaction may report target reached
    a_reached_goto: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.req_type != lls_pkg::REQ_GOTO) |=> !out_reg.target_reached)
        else $error("target reached set outside go-to-angle");

    // both stages full and result stalled: no new request taken
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && !rsp.ready) |-> !req.ready)
        else $error("request accepted while pipeline full");

    // a held result is not dropped without a handshake
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && out_vld_reg) |=> out_vld_reg || $past(rsp.ready))
        else $error("result dropped without handshake");
`endif

endmodule

`default_nettype wire

FILE: design/lls_regs.sv
// lls_regs: APB-style configuration register file
// depends on lls_pkg for the register map and cfg_t
`default_nettype none

module lls_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lls_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output lls_pkg::cfg_t                    cfg
);

    lls_pkg::cfg_t                   cfg_reg;
    lls_pkg::cfg_t                   cfg_next;
    logic [lls_pkg::REG_IDX_W-1:0]   idx;
    logic                            wr_en;

    assign idx    = paddr[lls_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                lls_pkg::REG_DEADBAND:        cfg_next.deadband        = pwdata[14:0];
                lls_pkg::REG_SPEED_CAP:       cfg_next.speed_cap       = pwdata[14:0];
                lls_pkg::REG_ANGLE_MARGIN:    cfg_next.angle_margin    = pwdata[15:0];
                lls_pkg::REG_APPROACH_SPEED:  cfg_next.approach_speed  = pwdata[14:0];
                lls_pkg::REG_ANGLE_PER_COUNT: cfg_next.angle_per_count = pwdata[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lls_pkg::REG_DEADBAND:        prdata = {17'd0, cfg_reg.deadband};
            lls_pkg::REG_SPEED_CAP:       prdata = {17'd0, cfg_reg.speed_cap};
            lls_pkg::REG_ANGLE_MARGIN:    prdata = {16'd0, cfg_reg.angle_margin};
            lls_pkg::REG_APPROACH_SPEED:  prdata = {17'd0, cfg_reg.approach_speed};
            lls_pkg::REG_ANGLE_PER_COUNT: prdata = {16'd0, cfg_reg.angle_per_count};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband        <= lls_pkg::DEADBAND_RST;
            cfg_reg.speed_cap       <= lls_pkg::SPEED_CAP_RST;
            cfg_reg.angle_margin    <= lls_pkg::ANGLE_MARGIN_RST;
            cfg_reg.approach_speed  <= lls_pkg::APPROACH_SPEED_RST;
            cfg_reg.angle_per_count <= lls_pkg::ANGLE_PER_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lls_step.sv
// lls_step: combinational step logic, one request in, one result and next state out
// depends on lls_pkg for cfg_t, req_t, rsp_t, state_t and constants
`default_nettype none

module lls_step (
    input  wire lls_pkg::cfg_t    cfg,
    input  wire lls_pkg::req_t    req,
    input  wire lls_pkg::state_t  st,
    output lls_pkg::state_t       st_out,
    output lls_pkg::rsp_t         rsp
);

    localparam int SP_W     = 17;
    localparam int SUM_W    = 18;
    localparam int PROD_W   = 49;
    localparam int DIFF_W   = 50;
    localparam int BIAS_W_L = lls_pkg::BIAS_W;

    logic                      low_hit;
    logic                      high_hit;
    logic signed [31:0]        pos;
    logic signed [PROD_W-1:0]  pos_x;
    logic signed [PROD_W-1:0]  apc_x;
    logic signed [PROD_W-1:0]  ang;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         abs_diff;
    logic                      reached;
    logic signed [BIAS_W_L-1:0] hb_new;
    logic signed [SP_W-1:0]    sp;
    logic signed [SP_W-1:0]    db;
    logic signed [SP_W-1:0]    cap;
    logic signed [SUM_W-1:0]   sum;
    logic signed [15:0]        sum_sat;
    logic signed [15:0]        man_drive;
    logic                      man_top;
    logic signed [31:0]        man_offset;
    logic signed [15:0]        drive;

    // a stop reads as pressed unless both of its inputs are clear
    assign low_hit  = !(req.low_switch_a && req.low_switch_b);
    assign high_hit = !(req.high_switch_a && req.high_switch_b);

    assign pos   = req.encoder_raw - st.count_offset;
    assign pos_x = {{(PROD_W-32){pos[31]}}, pos};
    assign apc_x = {{(PROD_W-lls_pkg::APC_W){1'b0}}, cfg.angle_per_count};
    assign ang   = pos_x * apc_x;
    assign diff  = {{(DIFF_W-lls_pkg::ANGLE_W){req.target_angle[15]}}, req.target_angle}
                 - {ang[PROD_W-1], ang};
    assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign reached  = {{(DIFF_W-lls_pkg::MARGIN_W){1'b0}}, cfg.angle_margin} >= abs_diff;

    always_comb
    begin
        if (pos < lls_pkg::BAND_MID)
            hb_new = lls_pkg::BIAS_LOW;
        else if (pos < lls_pkg::BAND_HIGH)
            hb_new = lls_pkg::BIAS_MID;
        else
            hb_new = lls_pkg::BIAS_HIGH;
    end

    assign db  = $signed({2'b00, cfg.deadband});
    assign cap = $signed({2'b00, cfg.speed_cap});

    // speed fed to the manual path: request speed, or bang-bang toward target and the stored hold bias once reached
    always_comb
    begin
        if (req.req_type == lls_pkg::REQ_GOTO)
        begin
            if (reached)
                sp = SP_W'(st.hold_bias);
            else if (diff[DIFF_W-1])
                sp = -$signed({2'b00, cfg.approach_speed});
            else
                sp = $signed({2'b00, cfg.approach_speed});
        end
        else
        begin
            sp = SP_W'(req.lifter_speed);
        end
    end

    assign sum = SUM_W'(sp) + SUM_W'(hb_new);

    always_comb
    begin
        if (sum > 18'sd32767)
            sum_sat = 16'sh7fff;
        else if (sum < -18'sd32768)
            sum_sat = 16'sh8000;
        else
            sum_sat = sum[15:0];
    end

    always_comb
    begin
        man_offset = st.count_offset;
        man_top    = st.top_latched;
        if (low_hit && sp > 0)
        begin
            man_drive = 16'sd0;
        end
        else if (high_hit && sp < 0)
        begin
            // reaching the high stop re-zeroes the encoder
            man_drive  = 16'sd0;
            man_offset = req.encoder_raw;
            man_top    = 1'b1;
        end
        else if (sp < db && sp > -db)
        begin
            man_drive = 16'(hb_new);
        end
        else if (sp > cap)
        begin
            man_drive = cap[15:0];
        end
        else if (sp < -cap)
        begin
            man_drive = 16'(-cap);
        end
        else
        begin
            man_drive = sum_sat;
        end
        if (sp > 0)
            man_top = 1'b0;
    end

    always_comb
    begin
        st_out = st;
        drive  = st.last_drive;
        unique case (req.req_type) inside
            lls_pkg::REQ_MANUAL, lls_pkg::REQ_GOTO:
            begin
                drive              = man_drive;
                st_out.hold_bias   = hb_new;
                st_out.count_offset = man_offset;
                st_out.top_latched = man_top;
            end
            lls_pkg::REQ_HOLD_TOP:
            begin
                if (st.top_latched)
                    drive = high_hit ? 16'sd0 : 16'(-cap);
            end
            lls_pkg::REQ_ZERO:
            begin
                st_out.count_offset = req.encoder_raw;
            end
            default:
            begin
                drive = st.last_drive;
            end
        endcase
        st_out.last_drive = drive;
    end

    assign rsp.lifter_drive   = drive;
    assign rsp.target_reached = (req.req_type == lls_pkg::REQ_GOTO) && reached;
    assign rsp.top_flag       = st_out.top_latched;
    assign rsp.position_count = req.encoder_raw - st_out.count_offset;

endmodule

`default_nettype wire

FILE: tb/sv/lls_checker.sv
// lls_checker: watches the request, result and APB channels of the lifter drive unit,
// predicts every result from its own copy of the lifter state and compares field by field
// depends on lls_pkg for types and constants and on lls_if for the channel interfaces
`default_nettype none

module lls_checker
    import lls_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    lls_req_if                     req_mon,
    lls_rsp_if                     rsp_mon,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output int                     mismatches,
    output int                     pending,
    output int                     checked,
    output int                     arrivals
);

    cfg_t                      cfg;
    logic signed [SPEED_W-1:0] bias_now;
    bit                        at_top;
    logic [COUNT_W-1:0]        zero_offset;
    logic signed [SPEED_W-1:0] prev_drive;
    rsp_t                      due_results[$];

    initial begin
        mismatches = 0;
        checked    = 0;
        arrivals   = 0;
        pending    = 0;
    end

    // drive from a speed request, updates bias band, zero offset and top flag
    function automatic logic signed [SPEED_W-1:0] lift_drive(int speed,
                                                             logic [COUNT_W-1:0] raw,
                                                             bit low_hit, bit high_hit);
        int pos;
        int drive;
        int db;
        int cap;
        db  = int'(cfg.deadband);
        cap = int'(cfg.speed_cap);
        pos = int'(raw - zero_offset);
        if (pos < BAND_MID)
            bias_now = BIAS_LOW;
        else if (pos < BAND_HIGH)
            bias_now = BIAS_MID;
        else
            bias_now = BIAS_HIGH;

        if (low_hit && speed > 0)
            drive = 0;
        else if (high_hit && speed < 0)
        begin
            drive       = 0;
            zero_offset = raw;
            at_top      = 1'b1;
        end
        else if (speed < db && speed > -db)
            drive = int'(bias_now);
        else if (speed > cap)
            drive = cap;
        else if (speed < -cap)
            drive = -cap;
        else
        begin
            drive = speed + int'(bias_now);
            if (drive > 32767)
                drive = 32767;
            if (drive < -32768)
                drive = -32768;
        end
        if (speed > 0)
            at_top = 1'b0;
        return drive[SPEED_W-1:0];
    endfunction

    function automatic rsp_t lifter_step(req_t r);
        rsp_t                      res;
        bit                        low_hit;
        bit                        high_hit;
        int                        pos;
        longint                    angle;
        longint                    gap;
        logic signed [SPEED_W-1:0] drive;
        low_hit  = !(r.low_switch_a && r.low_switch_b);
        high_hit = !(r.high_switch_a && r.high_switch_b);
        drive    = prev_drive;
        res.target_reached = 1'b0;
        case (r.req_type)
            REQ_MANUAL:
                drive = lift_drive(int'(r.lifter_speed), r.encoder_raw, low_hit, high_hit);
            REQ_GOTO:
            begin
                pos   = int'(r.encoder_raw - zero_offset);
                angle = longint'(pos) * longint'(cfg.angle_per_count);
                gap   = longint'(r.target_angle) - angle;
                if (gap < 0)
                    gap = -gap;
                if (longint'(cfg.angle_margin) >= gap)
                begin
                    drive = lift_drive(int'(bias_now), r.encoder_raw, low_hit, high_hit);
                    res.target_reached = 1'b1;
                end
                else if (angle > longint'(r.target_angle))
                    drive = lift_drive(-int'(cfg.approach_speed), r.encoder_raw,
                                       low_hit, high_hit);
                else
                    drive = lift_drive(int'(cfg.approach_speed), r.encoder_raw,
                                       low_hit, high_hit);
            end
            REQ_HOLD_TOP:
                if (at_top)
                    drive = high_hit ? 0 : -int'(cfg.speed_cap);
            REQ_ZERO:
                zero_offset = r.encoder_raw;
        endcase
        prev_drive         = drive;
        res.lifter_drive   = drive;
        res.top_flag       = at_top;
        res.position_count = r.encoder_raw - zero_offset;
        return res;
    endfunction

    task automatic compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        req_t got;
        rsp_t want;
        if (!rst_n)
        begin
            cfg.deadband        = DEADBAND_RST;
            cfg.speed_cap       = SPEED_CAP_RST;
            cfg.angle_margin    = ANGLE_MARGIN_RST;
            cfg.approach_speed  = APPROACH_SPEED_RST;
            cfg.angle_per_count = ANGLE_PER_COUNT_RST;
            bias_now    = '0;
            at_top      = 1'b1;
            zero_offset = '0;
            prev_drive  = '0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_DEADBAND:        cfg.deadband        = pwdata[MAG_W-1:0];
                    REG_SPEED_CAP:       cfg.speed_cap       = pwdata[MAG_W-1:0];
                    REG_ANGLE_MARGIN:    cfg.angle_margin    = pwdata[MARGIN_W-1:0];
                    REG_APPROACH_SPEED:  cfg.approach_speed  = pwdata[MAG_W-1:0];
                    REG_ANGLE_PER_COUNT: cfg.angle_per_count = pwdata[APC_W-1:0];
                    default: ;
                endcase
            end

            if (req_mon.valid && req_mon.ready)
            begin
                got.req_type      = req_mon.req_type;
                got.lifter_speed  = req_mon.lifter_speed;
                got.target_angle  = req_mon.target_angle;
                got.encoder_raw   = req_mon.encoder_raw;
                got.low_switch_a  = req_mon.low_switch_a;
                got.low_switch_b  = req_mon.low_switch_b;
                got.high_switch_a = req_mon.high_switch_a;
                got.high_switch_b = req_mon.high_switch_b;
                due_results.push_back(lifter_step(got));
            end

            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result transaction with none expected, drive %0d",
                             $time, rsp_mon.lifter_drive);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("lifter_drive", longint'(want.lifter_drive),
                                  longint'(rsp_mon.lifter_drive));
                    compare_field("target_reached", longint'(want.target_reached),
                                  longint'(rsp_mon.target_reached));
                    compare_field("top_flag", longint'(want.top_flag),
                                  longint'(rsp_mon.top_flag));
                    compare_field("position_count", longint'(want.position_count),
                                  longint'(rsp_mon.position_count));
                    checked++;
                    if (want.target_reached)
                        arrivals++;
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: clock, reset, request and APB stimulus and the verdict for the lifter drive unit
// depends on lls_pkg, lls_if, lifter_limit_switch_drive_unit and lls_checker
`default_nettype none

module tb_top;
    import lls_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int PHASES         = 6;
    localparam logic [3:0] SW_CLEAR = 4'b1111;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic [8:0]        stall_tick = '0;

    int mismatch_count;
    int pending;
    int checked;
    int arrivals;

    // what the stimulus knows of the current settings and zero point
    int                 cur_deadband = DEADBAND_RST;
    int                 cur_cap      = SPEED_CAP_RST;
    int                 cur_margin   = ANGLE_MARGIN_RST;
    int                 cur_apc      = ANGLE_PER_COUNT_RST;
    logic [COUNT_W-1:0] zero_guess   = '0;

    lls_req_if req_ch();
    lls_rsp_if rsp_ch();

    lifter_limit_switch_drive_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lls_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatch_count),
        .pending    (pending),
        .checked    (checked),
        .arrivals   (arrivals)
    );

    always #4 clk = ~clk;

    // result side: always ready, mostly ready, mostly stalled, then a fixed pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[8:7])
            2'd0:    rsp_ch.ready <= 1'b1;
            2'd1:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (stall_tick[2:0] != 3'd5) && (stall_tick[2:0] != 3'd6);
        endcase
    end

    function automatic req_t mk(logic [REQ_W-1:0] kind, int speed, int target,
                                logic [COUNT_W-1:0] raw, logic [3:0] sw);
        req_t r;
        r.req_type      = kind;
        r.lifter_speed  = speed[SPEED_W-1:0];
        r.target_angle  = target[ANGLE_W-1:0];
        r.encoder_raw   = raw;
        r.low_switch_a  = sw[3];
        r.low_switch_b  = sw[2];
        r.high_switch_a = sw[1];
        r.high_switch_b = sw[0];
        return r;
    endfunction

    function automatic req_t random_item();
        req_t   r;
        int     roll;
        int     pos;
        int     speed;
        longint aim;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.req_type = REQ_MANUAL;
        else if (roll < 75)
            r.req_type = REQ_GOTO;
        else if (roll < 88)
            r.req_type = REQ_HOLD_TOP;
        else
            r.req_type = REQ_ZERO;

        // positions mostly around the bias bands relative to the last zero point
        pos = int'($urandom_range(0, 460)) - 60;
        if ($urandom_range(0, 19) == 0)
            r.encoder_raw = $urandom;
        else
            r.encoder_raw = zero_guess + pos;

        case ($urandom_range(0, 5))
            0:       speed = int'($urandom_range(0, 65535)) - 32768;
            1:       speed = int'($urandom_range(0, 2 * cur_deadband)) - cur_deadband;
            2:       speed = ($urandom_range(0, 1) ? cur_deadband : -cur_deadband)
                             + int'($urandom_range(0, 2)) - 1;
            3:       speed = ($urandom_range(0, 1) ? cur_cap : -cur_cap)
                             + int'($urandom_range(0, 2)) - 1;
            4:       speed = $urandom_range(0, 1) ? 32767 : -32768;
            default: speed = int'($urandom_range(0, 40000)) - 20000;
        endcase
        r.lifter_speed = speed[SPEED_W-1:0];

        // aim most go-to targets close to the present angle so the margin matters
        if (r.req_type == REQ_GOTO && $urandom_range(0, 9) < 7)
        begin
            aim = longint'(pos) * cur_apc + int'($urandom_range(0, 2 * cur_margin + 64))
                  - cur_margin - 32;
            if (aim > 32767)
                aim = 32767;
            if (aim < -32768)
                aim = -32768;
            r.target_angle = aim[ANGLE_W-1:0];
        end
        else
            r.target_angle = $urandom_range(0, 65535);

        r.low_switch_a  = ($urandom_range(0, 7) != 0);
        r.low_switch_b  = ($urandom_range(0, 7) != 0);
        r.high_switch_a = ($urandom_range(0, 7) != 0);
        r.high_switch_b = ($urandom_range(0, 7) != 0);
        return r;
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(int db, int cap, int margin, int approach, int apc);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_SPEED_CAP, cap);
        write_reg(REG_ANGLE_MARGIN, margin);
        write_reg(REG_APPROACH_SPEED, approach);
        write_reg(REG_ANGLE_PER_COUNT, apc);
        cur_deadband = db;
        cur_cap      = cap;
        cur_margin   = margin;
        cur_apc      = apc;
    endtask

    task automatic send_item(req_t r);
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.lifter_speed  <= r.lifter_speed;
        req_ch.target_angle  <= r.target_angle;
        req_ch.encoder_raw   <= r.encoder_raw;
        req_ch.low_switch_a  <= r.low_switch_a;
        req_ch.low_switch_b  <= r.low_switch_b;
        req_ch.high_switch_a <= r.high_switch_a;
        req_ch.high_switch_b <= r.high_switch_b;
        do @(posedge clk); while (!req_ch.ready);
        if (r.req_type == REQ_ZERO)
            zero_guess = r.encoder_raw;
    endtask

    // valid low with junk on the payload, which must be ignored
    task automatic pause_sender(int cycles);
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= $urandom_range(0, 3);
        req_ch.lifter_speed  <= $urandom_range(0, 65535);
        req_ch.target_angle  <= $urandom_range(0, 65535);
        req_ch.encoder_raw   <= $urandom;
        req_ch.low_switch_a  <= $urandom_range(0, 1);
        req_ch.low_switch_b  <= $urandom_range(0, 1);
        req_ch.high_switch_a <= $urandom_range(0, 1);
        req_ch.high_switch_b <= $urandom_range(0, 1);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic run_random(int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_item(random_item());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
                pause_sender(gap);
        end
    endtask

    // lets every outstanding result come back before the settings change
    // the checker count is registered, so look at it only from the next edge on
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        req_t opening[$];
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_MANUAL;
        req_ch.lifter_speed  = '0;
        req_ch.target_angle  = '0;
        req_ch.encoder_raw   = '0;
        req_ch.low_switch_a  = 1'b1;
        req_ch.low_switch_b  = 1'b1;
        req_ch.high_switch_a = 1'b1;
        req_ch.high_switch_b = 1'b1;
        rsp_ch.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: hold at top, stops, deadband and band edges, wrap, go-to cases
        opening.push_back(mk(REQ_HOLD_TOP, 0, 0, 32'd0, SW_CLEAR));
        opening.push_back(mk(REQ_HOLD_TOP, 0, 0, 32'd0, 4'b1110));
        opening.push_back(mk(REQ_MANUAL, 0, 0, 32'd50, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 1000, 0, 32'd150, SW_CLEAR));
        opening.push_back(mk(REQ_HOLD_TOP, 0, 0, 32'd150, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 32767, 0, 32'd500, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, -32768, 0, 32'd1000, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 10000, 0, 32'd1000, 4'b1011));
        opening.push_back(mk(REQ_MANUAL, -10000, 0, 32'd12345, 4'b1101));
        opening.push_back(mk(REQ_MANUAL, 10000, 0, 32'd12595, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 3277, 0, 32'd12445, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, -3277, 0, 32'd12544, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, -3276, 0, 32'd12545, SW_CLEAR));
        opening.push_back(mk(REQ_ZERO, 0, 0, 32'h7fff_ffff, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 5000, 0, 32'h8000_0000, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, 300, 32'h8000_0001, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, 32767, 32'h8000_0001, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, -32768, 32'h8000_0097, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, -32768, 32'h8000_0097, 4'b1110));
        opening.push_back(mk(REQ_GOTO, 0, 0, 32'h8000_0097, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, 512, 32'h8000_0097, SW_CLEAR));
        opening.push_back(mk(REQ_GOTO, 0, 513, 32'h8000_0097, 4'b0111));
        opening.push_back(mk(REQ_ZERO, 0, 0, 32'hffff_ffff, SW_CLEAR));
        opening.push_back(mk(REQ_MANUAL, 16385, 0, 32'd5, SW_CLEAR));
        foreach (opening[i])
            send_item(opening[i]);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:       set_config(0, 32767, 0, 32767, 65535);
                2:       set_config(32767, 0, 65535, 0, 0);
                4:       set_config(32767, 32767, 0, 1, 1);
                default: set_config($urandom_range(0, 6000), $urandom_range(4000, 32767),
                                    $urandom_range(0, 2048), $urandom_range(0, 32767),
                                    $urandom_range(1, 1024));
            endcase
            if (phase == 1)
            begin
                // full cap with the highest bias drives the sum past the 16 bit range
                send_item(mk(REQ_ZERO, 0, 0, 32'h0000_1000, SW_CLEAR));
                send_item(mk(REQ_MANUAL, -32767, 0, 32'h0000_112c, SW_CLEAR));
                send_item(mk(REQ_MANUAL, 32767, 0, 32'h0000_112c, SW_CLEAR));
                send_item(mk(REQ_GOTO, 0, 32767, 32'h0000_112c, SW_CLEAR));
            end
            run_random(RANDOM_ITEMS / PHASES);
            drain();
        end

        repeat (8) @(posedge clk);
        $display("checked %0d result transactions over %0d register settings, %0d at target",
                 checked, PHASES + 1, arrivals);
        if (mismatch_count == 0)
            $display("lifter_limit_switch_drive_unit regression: pass");
        else
            $display("lifter_limit_switch_drive_unit regression: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("timeout with %0d results outstanding", pending);
        $display("lifter_limit_switch_drive_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/lls_pkg.sv
design/lls_if.sv
design/lls_regs.sv
design/lls_step.sv
design/lifter_limit_switch_drive_unit.sv
tb/sv/lls_checker.sv
tb/sv/tb_top.sv
